// File: rtl/core/h264_rtp_fu_a_packetizer_assert.svh
// ---------------------------------------------------------------------------
// H.264 RTP FU-A packetizer assertion macros
// Shared concurrent-assertion forms, sampled on clock, off during reset.
// ---------------------------------------------------------------------------
`ifndef H264_RTP_FU_A_PACKETIZER_ASSERT_SVH
`define H264_RTP_FU_A_PACKETIZER_ASSERT_SVH

// Same-cycle implication
`define HFU_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("packetizer check failed");

// Next-cycle implication
`define HFU_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("packetizer check failed");

`endif

// File: rtl/core/hfu_pkg.sv
// ---------------------------------------------------------------------------
// hfu_pkg
// Types and constants of the H.264 RTP FU-A packetizer.
// ---------------------------------------------------------------------------
package hfu_pkg;

   // Default largest NAL unit in bytes
   localparam int unsigned HFU_MAX_NAL_BYTES = 65536;

   // Configuration register indexes
   localparam int unsigned HFU_CSR_IDX_W = 2;
   localparam logic [HFU_CSR_IDX_W-1:0] HFU_REG_PAYLOAD_TYPE = 2'd0;
   localparam logic [HFU_CSR_IDX_W-1:0] HFU_REG_SSRC         = 2'd1;
   localparam logic [HFU_CSR_IDX_W-1:0] HFU_REG_MAX_PAYLOAD  = 2'd2;
   localparam int unsigned HFU_CSR_DATA_W = 32;

   // Register reset values
   localparam logic [6:0]  HFU_PT_RESET   = 7'd96;
   localparam logic [31:0] HFU_SSRC_RESET = 32'd0;
   localparam logic [15:0] HFU_MAXP_RESET = 16'd1400;

   // Payload constants
   localparam logic [15:0] HFU_MIN_MAXP   = 16'd3;
   localparam logic [15:0] HFU_FU_HDR_LEN = 16'd2;
   localparam logic [7:0]  HFU_NRI_MASK   = 8'hE0;
   localparam logic [7:0]  HFU_TYPE_MASK  = 8'h1F;
   localparam logic [7:0]  HFU_FU_A_TYPE  = 8'd28;
   localparam logic [7:0]  HFU_FU_START   = 8'h80;
   localparam logic [7:0]  HFU_FU_END     = 8'h40;

   // Input item
   typedef struct packed {
      logic [7:0]  nal_byte;
      logic [16:0] nal_length;
      logic [31:0] nal_timestamp;
   } hfu_req_type;

   // Result item
   typedef struct packed {
      logic [7:0]  payload_out;
      logic        packet_start;
      logic        packet_end;
      logic [15:0] header_sequence;
      logic [31:0] header_timestamp;
      logic        header_marker;
      logic [6:0]  header_payload_type;
      logic [31:0] header_ssrc;
      logic        run_last;
   } hfu_rsp_type;

   // One buffered result byte with its per-byte flags
   typedef struct packed {
      logic [7:0] data;
      logic       start;
      logic       stop;
      logic       marker;
   } hfu_entry_type;

   // Fields shared by all results of one input byte
   typedef struct packed {
      logic [15:0] seq;
      logic [31:0] timestamp;
      logic [6:0]  pt;
      logic [31:0] ssrc;
   } hfu_common_type;

endpackage

// File: rtl/core/hfu_channels.sv
// ---------------------------------------------------------------------------
// hfu channel interfaces
// Valid/ready channels for NAL input bytes and packet payload results.
// ---------------------------------------------------------------------------
interface hfu_req_if import hfu_pkg::*; ();
   logic        valid;
   logic        ready;
   hfu_req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface hfu_rsp_if import hfu_pkg::*; ();
   logic        valid;
   logic        ready;
   hfu_rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/core/h264_rtp_fu_a_packetizer.sv
// ---------------------------------------------------------------------------
// h264_rtp_fu_a_packetizer
// Cuts a byte stream of H.264 NAL units into single-NAL and FU-A RTP payloads.
// ---------------------------------------------------------------------------
// Usage:
//   req_chan takes one NAL byte per transfer, header byte first; nal_length
//   and nal_timestamp are sampled only on a unit's first byte.
//   rsp_chan gives one payload byte per transfer with packet framing and the
//   RTP header fields of its packet; run_last flags the final result of a
//   given input byte. The held NAL header of a fragmented unit gives none.
//   csr_we/csr_index/csr_wdata write payload type, SSRC and max payload;
//   write only while the block is idle.
// Timing and throughput:
//   Results of a byte appear in the cycle after its transfer. A byte giving one
//   result or none is taken every cycle while rsp_chan is ready; a byte opening
//   a fragment gives three results, which the three-entry buffer sends one per
//   cycle while rsp_chan.ready is high, so req_chan.ready stays low until the
//   last of them is sent.
// Reset and stall:
//   Synchronous reset clears the unit and sequence state and reloads the
//   register defaults. When rsp_chan stalls, the buffer holds its bytes and
//   req_chan.ready drops as soon as the buffer cannot take a new byte.
// ---------------------------------------------------------------------------
`include "h264_rtp_fu_a_packetizer_assert.svh"

module h264_rtp_fu_a_packetizer
   import hfu_pkg::*;
#(
   parameter int unsigned MAX_NAL_BYTES = HFU_MAX_NAL_BYTES
) (
   input  logic                      clock,
   input  logic                      reset,
   hfu_req_if.sink                   req_chan,
   hfu_rsp_if.source                 rsp_chan,
   input  logic                      csr_we,
   input  logic [HFU_CSR_IDX_W-1:0]  csr_index,
   input  logic [HFU_CSR_DATA_W-1:0] csr_wdata
);

   // Saturated length, remaining count and compare widths
   localparam int unsigned LEN_W = $clog2(MAX_NAL_BYTES + 1);
   localparam int unsigned BL_W  = $clog2(MAX_NAL_BYTES);
   localparam int unsigned CMP_W = (LEN_W > 17) ? LEN_W : 17;

   // Configuration registers
   logic [6:0]  pt_ff;
   logic [31:0] ssrc_ff;
   logic [15:0] maxp_ff;

   // Unit state
   logic [BL_W-1:0] bytes_left_ff, bytes_left_in;
   logic [15:0]     chunk_left_ff, chunk_left_in;
   logic            fragmenting_ff, fragmenting_in;
   logic            first_frag_ff, first_frag_in;
   logic [7:0]      nal_hdr_ff, nal_hdr_in;
   logic [15:0]     seq_ff, seq_in;
   logic [31:0]     ts_ff, ts_in;

   // Result buffer
   hfu_entry_type  ent_ff [3];
   hfu_entry_type  ent_in [3];
   hfu_entry_type  new_ent [3];
   logic [1:0]     cnt_ff, cnt_in;
   logic [1:0]     new_cnt;
   hfu_common_type com_ff, com_in;

   logic            req_fire;
   logic            rsp_fire;
   logic            pop_last;
   logic [7:0]      in_byte;
   logic [CMP_W-1:0] len_raw;
   logic [LEN_W-1:0] len_sat;
   logic [15:0]     eff_maxp;
   logic [15:0]     room;
   logic [15:0]     chunk_sel;
   logic [15:0]     chunk_dec;
   logic [BL_W-1:0] bytes_dec;
   logic            frag_last;
   logic [7:0]      fu_hdr;

   // Handshakes
   assign rsp_fire       = rsp_chan.valid && rsp_chan.ready;
   assign pop_last       = rsp_fire && (cnt_ff == 2'd1);
   assign req_chan.ready = (cnt_ff == 2'd0) || pop_last;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign in_byte        = req_chan.payload.nal_byte;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pt_ff   <= HFU_PT_RESET;
         ssrc_ff <= HFU_SSRC_RESET;
         maxp_ff <= HFU_MAXP_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            HFU_REG_PAYLOAD_TYPE: pt_ff   <= csr_wdata[6:0];
            HFU_REG_SSRC:         ssrc_ff <= csr_wdata[31:0];
            HFU_REG_MAX_PAYLOAD:  maxp_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Clamped length and payload sizes
   always_comb begin
      len_raw = CMP_W'(req_chan.payload.nal_length);
      if (len_raw == '0) begin
         len_sat = LEN_W'(1);
      end else if (len_raw > CMP_W'(MAX_NAL_BYTES)) begin
         len_sat = LEN_W'(MAX_NAL_BYTES);
      end else begin
         len_sat = LEN_W'(len_raw);
      end
      eff_maxp = (maxp_ff < HFU_MIN_MAXP) ? HFU_MIN_MAXP : maxp_ff;
      room     = eff_maxp - HFU_FU_HDR_LEN;
   end

   // Per-byte packetizing step
   always_comb begin
      bytes_left_in  = bytes_left_ff;
      chunk_left_in  = chunk_left_ff;
      fragmenting_in = fragmenting_ff;
      first_frag_in  = first_frag_ff;
      nal_hdr_in     = nal_hdr_ff;
      seq_in         = seq_ff;
      ts_in          = ts_ff;
      new_cnt        = 2'd0;
      for (int i = 0; i < 3; i++) begin
         new_ent[i] = '0;
      end
      chunk_sel = chunk_left_ff;
      chunk_dec = '0;
      bytes_dec = '0;
      frag_last = 1'b0;
      fu_hdr    = '0;

      if (req_fire) begin
         if (bytes_left_ff == '0) begin
            // First byte of a unit
            ts_in         = req_chan.payload.nal_timestamp;
            first_frag_in = 1'b1;
            chunk_left_in = '0;
            bytes_left_in = BL_W'(len_sat - LEN_W'(1));
            if (CMP_W'(len_sat) <= CMP_W'(eff_maxp)) begin
               fragmenting_in = 1'b0;
               new_ent[0]     = '{data: in_byte, start: 1'b1,
                                  stop: (bytes_left_in == '0), marker: 1'b1};
               new_cnt        = 2'd1;
               if (bytes_left_in == '0) begin
                  seq_in = seq_ff + 16'd1;
               end
            end else begin
               fragmenting_in = 1'b1;
               nal_hdr_in     = in_byte;
            end
         end else if (!fragmenting_ff) begin
            // Body byte of a single-NAL packet
            bytes_left_in = bytes_left_ff - BL_W'(1);
            new_ent[0]    = '{data: in_byte, start: 1'b0,
                              stop: (bytes_left_in == '0), marker: 1'b1};
            new_cnt       = 2'd1;
            if (bytes_left_in == '0) begin
               seq_in = seq_ff + 16'd1;
            end
         end else begin
            // Fragment data byte, opening a new fragment when needed
            if (chunk_left_ff == '0) begin
               chunk_sel = (CMP_W'(bytes_left_ff) < CMP_W'(room)) ?
                           16'(bytes_left_ff) : room;
            end
            frag_last = (CMP_W'(chunk_sel) == CMP_W'(bytes_left_ff));
            if (chunk_left_ff == '0) begin
               fu_hdr = (nal_hdr_ff & HFU_TYPE_MASK)
                        | (first_frag_ff ? HFU_FU_START : 8'h00)
                        | (frag_last ? HFU_FU_END : 8'h00);
               new_ent[0] = '{data: (nal_hdr_ff & HFU_NRI_MASK) | HFU_FU_A_TYPE,
                              start: 1'b1, stop: 1'b0, marker: frag_last};
               new_ent[1] = '{data: fu_hdr, start: 1'b0, stop: 1'b0,
                              marker: frag_last};
               new_ent[2] = '{data: in_byte, start: 1'b0,
                              stop: (chunk_sel == 16'd1), marker: frag_last};
               new_cnt       = 2'd3;
               first_frag_in = 1'b0;
            end else begin
               new_ent[0] = '{data: in_byte, start: 1'b0,
                              stop: (chunk_sel == 16'd1), marker: frag_last};
               new_cnt    = 2'd1;
            end
            chunk_dec     = chunk_sel - 16'd1;
            bytes_dec     = bytes_left_ff - BL_W'(1);
            chunk_left_in = chunk_dec;
            bytes_left_in = bytes_dec;
            if (chunk_dec == '0) begin
               seq_in = seq_ff + 16'd1;
            end
            if (bytes_dec == '0) begin
               fragmenting_in = 1'b0;
               chunk_left_in  = '0;
            end
         end
      end
   end

   // Result buffer: load on a producing transfer, shift on each output transfer
   always_comb begin
      ent_in = ent_ff;
      cnt_in = cnt_ff;
      com_in = com_ff;
      if (rsp_fire) begin
         ent_in[0] = ent_ff[1];
         ent_in[1] = ent_ff[2];
         cnt_in    = cnt_ff - 2'd1;
      end
      if (req_fire && (new_cnt != 2'd0)) begin
         ent_in = new_ent;
         cnt_in = new_cnt;
         com_in = '{seq: seq_ff, timestamp: ts_in,
                    pt: pt_ff, ssrc: ssrc_ff};
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff  <= '0;
         chunk_left_ff  <= '0;
         fragmenting_ff <= 1'b0;
         first_frag_ff  <= 1'b1;
         nal_hdr_ff     <= '0;
         seq_ff         <= '0;
         ts_ff          <= '0;
         cnt_ff         <= '0;
      end else begin
         bytes_left_ff  <= bytes_left_in;
         chunk_left_ff  <= chunk_left_in;
         fragmenting_ff <= fragmenting_in;
         first_frag_ff  <= first_frag_in;
         nal_hdr_ff     <= nal_hdr_in;
         seq_ff         <= seq_in;
         ts_ff          <= ts_in;
         cnt_ff         <= cnt_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
      com_ff <= com_in;
   end

   // Output drive
   assign rsp_chan.valid = (cnt_ff != 2'd0);
   assign rsp_chan.payload = '{
      payload_out:         ent_ff[0].data,
      packet_start:        ent_ff[0].start,
      packet_end:          ent_ff[0].stop,
      header_sequence:     com_ff.seq,
      header_timestamp:    com_ff.timestamp,
      header_marker:       ent_ff[0].marker,
      header_payload_type: com_ff.pt,
      header_ssrc:         com_ff.ssrc,
      run_last:            (cnt_ff == 2'd1)
   };

   // Checks
   `HFU_ASSERT_IMPL(a_accept_only_when_drained, req_fire, (cnt_ff == 2'd0) || pop_last)
   `HFU_ASSERT_IMPL(a_frag_has_bytes, fragmenting_ff, bytes_left_ff != '0)
   `HFU_ASSERT_IMPL(a_chunk_within_unit, fragmenting_ff && (chunk_left_ff != '0),
                    CMP_W'(chunk_left_ff) <= CMP_W'(bytes_left_ff))
   `HFU_ASSERT_NEXT(a_hold_when_stalled, rsp_chan.valid && !rsp_chan.ready,
                    rsp_chan.valid && $stable(cnt_ff))

endmodule
